[rtl/ptb_pkg.sv]
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants for the periodic timer bank: slot count, counter
// width, action and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package ptb_pkg;

	// Bank geometry.
	localparam int TIMER_SLOTS = 4;
	localparam int COUNT_BITS  = 16;
	localparam int IDX_W       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	// Fixed field widths of the ports.
	localparam int ACTION_W = 3;
	localparam int SLOT_W   = 2;
	localparam int FREQ_W   = 16;
	localparam int RATE_W   = 16;
	localparam int STATUS_W = 2;
	localparam int FIRE_W   = 4;

	// Divider step counter width (one quotient bit per cycle).
	localparam int DIV_CNT_W = $clog2(FREQ_W);

	localparam logic [RATE_W-1:0]     TICK_RATE_RESET = 16'd100;
	localparam logic [COUNT_BITS-1:0] COUNT_MASK      = '1;

	// Actions carried by an input transaction.
	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK     = 3'd0,
		ACT_ADD      = 3'd1,
		ACT_DELETE   = 3'd2,
		ACT_SET_FREQ = 3'd3,
		ACT_ENABLE   = 3'd4,
		ACT_DISABLE  = 3'd5,
		ACT_RESTART  = 3'd6,
		ACT_NONE     = 3'd7
	} action_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_ZERO_FREQ = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_APPLY,
		S_DIV,
		S_TICK,
		S_FINISH
	} ctl_state_t;

endpackage

[rtl/periodic_timer_bank_core.sv]
// ----------------------------------------------------------------------------
// periodic_timer_bank_core
// Bank of periodic reload timers driven by one action per input transaction.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction (in_valid/in_ready) carries an action, a slot, a
// frequency and a start-enabled bit. Each one produces exactly one output
// transaction (out_valid/out_ready) with a status, the granted slot and the
// mask of slots that fired on a tick. The tick_rate register is written over
// the cfg_valid/cfg_ready/cfg_data channel, which is always ready.
// From acceptance, a rejected add or set frequency goes straight to the
// finish state; delete, enable, disable, restart and the unused action pass
// through the apply state first; a tick walks the slots one per cycle through
// a shared decrement path; and add and set frequency run a restoring divider
// that produces one quotient bit per cycle. in_ready is high only while the
// sequencer is idle, so one transaction is in work at a time.
// The result sits in an output register, so the next transaction is taken
// while a result still waits; if the receiver stalls and the output register
// is full, the sequencer holds its finished result until the register frees.
// Reset clears all allocated and enabled marks and sets tick_rate to 100.
// ----------------------------------------------------------------------------
module periodic_timer_bank_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ptb_pkg::RATE_W-1:0]          cfg_data,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ptb_pkg::ACTION_W-1:0]        action,
	input  logic [ptb_pkg::SLOT_W-1:0]          slot,
	input  logic [ptb_pkg::FREQ_W-1:0]          frequency,
	input  logic                                start_enabled,
	// Output channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ptb_pkg::STATUS_W-1:0]        status,
	output logic [ptb_pkg::SLOT_W-1:0]          granted_slot,
	output logic [ptb_pkg::FIRE_W-1:0]          fire_mask
);

	// Sequencer state.
	ptb_pkg::ctl_state_t state_q, state_d;

	// Configuration register.
	logic [ptb_pkg::RATE_W-1:0] tick_rate_q;

	// Slot storage.
	logic [ptb_pkg::TIMER_SLOTS-1:0] alloc_q;
	logic [ptb_pkg::TIMER_SLOTS-1:0] enab_q;
	logic [ptb_pkg::COUNT_BITS-1:0]  countdown_q [ptb_pkg::TIMER_SLOTS];
	logic [ptb_pkg::COUNT_BITS-1:0]  reload_q    [ptb_pkg::TIMER_SLOTS];

	// Working registers of the transaction in progress.
	ptb_pkg::action_t                action_q;
	logic [ptb_pkg::FREQ_W-1:0]      freq_q;
	logic                            start_q;
	logic                            slot_ok_q;
	logic [ptb_pkg::IDX_W-1:0]       idx_q;
	ptb_pkg::status_t                res_status_q;
	logic [ptb_pkg::SLOT_W-1:0]      res_grant_q;
	logic [ptb_pkg::TIMER_SLOTS-1:0] res_fire_q;

	// Divider registers.
	logic [ptb_pkg::FREQ_W:0]         rem_q;
	logic [ptb_pkg::FREQ_W-1:0]       quo_q;
	logic [ptb_pkg::DIV_CNT_W-1:0]    div_cnt_q;

	// Output register.
	logic                            out_valid_q;
	ptb_pkg::status_t                status_q;
	logic [ptb_pkg::SLOT_W-1:0]      granted_q;
	logic [ptb_pkg::FIRE_W-1:0]      fire_q;

	// Combinational helpers.
	logic                            in_fire;
	logic                            out_load;
	logic                            any_free;
	logic [ptb_pkg::IDX_W-1:0]       free_idx;
	logic                            in_slot_ok;
	logic [ptb_pkg::IDX_W-1:0]       cap_idx;
	ptb_pkg::status_t                cap_status;
	logic [ptb_pkg::SLOT_W-1:0]      cap_grant;
	logic [ptb_pkg::FREQ_W:0]        trial;
	logic                            trial_ge;
	logic [ptb_pkg::FREQ_W-1:0]      quo_next;
	logic [31:0]                     quo_wide;
	logic [ptb_pkg::COUNT_BITS-1:0]  period;
	logic [ptb_pkg::COUNT_BITS-1:0]  cd_rd;
	logic [ptb_pkg::COUNT_BITS-1:0]  rl_rd;
	logic                            last_slot;
	logic                            div_last;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ptb_pkg::S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == ptb_pkg::S_FINISH) && (!out_valid_q || out_ready);

	assign in_slot_ok = (32'(slot) < ptb_pkg::TIMER_SLOTS);

	// Lowest free slot, searched over the allocated marks.
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = ptb_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!alloc_q[i]) begin
				any_free = 1'b1;
				free_idx = ptb_pkg::IDX_W'(i);
			end
		end
	end

	// Working index, status and granted slot of an incoming transaction.
	always_comb begin
		cap_idx    = slot[ptb_pkg::IDX_W-1:0];
		cap_status = ptb_pkg::STAT_OK;
		cap_grant  = '0;
		case (ptb_pkg::action_t'(action))
			ptb_pkg::ACT_TICK: begin
				cap_idx = '0;
			end
			ptb_pkg::ACT_ADD: begin
				if (frequency == '0) begin
					cap_status = ptb_pkg::STAT_ZERO_FREQ;
				end else if (!any_free) begin
					cap_status = ptb_pkg::STAT_FULL;
				end else begin
					cap_idx   = free_idx;
					cap_grant = ptb_pkg::SLOT_W'(free_idx);
				end
			end
			ptb_pkg::ACT_SET_FREQ: begin
				if (frequency == '0) begin
					cap_status = ptb_pkg::STAT_ZERO_FREQ;
				end
			end
			default: ;
		endcase
	end

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	assign trial    = {rem_q[ptb_pkg::FREQ_W-1:0], quo_q[ptb_pkg::FREQ_W-1]};
	assign trial_ge = (trial >= {1'b0, freq_q});
	assign quo_next = {quo_q[ptb_pkg::FREQ_W-2:0], trial_ge};
	assign div_last = (div_cnt_q == ptb_pkg::DIV_CNT_W'(ptb_pkg::FREQ_W - 1));

	// Saturate the quotient to the counter width.
	assign quo_wide = 32'(quo_next);
	assign period   = (quo_wide > 32'(ptb_pkg::COUNT_MASK)) ? ptb_pkg::COUNT_MASK
	                                                        : ptb_pkg::COUNT_BITS'(quo_wide);

	// Slot storage is read at the single working index.
	assign cd_rd     = countdown_q[idx_q];
	assign rl_rd     = reload_q[idx_q];
	assign last_slot = (idx_q == ptb_pkg::IDX_W'(ptb_pkg::TIMER_SLOTS - 1));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptb_pkg::S_IDLE: begin
				if (in_fire) begin
					case (ptb_pkg::action_t'(action))
						ptb_pkg::ACT_TICK: begin
							state_d = ptb_pkg::S_TICK;
						end
						ptb_pkg::ACT_ADD: begin
							if (frequency == '0 || !any_free) begin
								state_d = ptb_pkg::S_FINISH;
							end else begin
								state_d = ptb_pkg::S_DIV;
							end
						end
						ptb_pkg::ACT_SET_FREQ: begin
							if (frequency == '0 || !in_slot_ok) begin
								state_d = ptb_pkg::S_FINISH;
							end else begin
								state_d = ptb_pkg::S_DIV;
							end
						end
						default: begin
							state_d = ptb_pkg::S_APPLY;
						end
					endcase
				end
			end
			ptb_pkg::S_APPLY: begin
				state_d = ptb_pkg::S_FINISH;
			end
			ptb_pkg::S_DIV: begin
				if (div_last) begin
					state_d = ptb_pkg::S_FINISH;
				end
			end
			ptb_pkg::S_TICK: begin
				if (last_slot) begin
					state_d = ptb_pkg::S_FINISH;
				end
			end
			ptb_pkg::S_FINISH: begin
				if (out_load) begin
					state_d = ptb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ptb_pkg::S_IDLE;
			end
		endcase
	end

	// Configuration register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= ptb_pkg::TICK_RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tick_rate_q <= cfg_data;
		end
	end

	// Allocated and enabled marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
			enab_q  <= '0;
		end else begin
			if (state_q == ptb_pkg::S_APPLY && slot_ok_q) begin
				case (action_q)
					ptb_pkg::ACT_DELETE:  alloc_q[idx_q] <= 1'b0;
					ptb_pkg::ACT_ENABLE:  enab_q[idx_q]  <= 1'b1;
					ptb_pkg::ACT_DISABLE: enab_q[idx_q]  <= 1'b0;
					default: ;
				endcase
			end
			if (state_q == ptb_pkg::S_DIV && div_last && action_q == ptb_pkg::ACT_ADD) begin
				alloc_q[idx_q] <= 1'b1;
				enab_q[idx_q]  <= start_q;
			end
		end
	end

	// Countdown and reload storage.
	always_ff @(posedge clk) begin
		if (state_q == ptb_pkg::S_DIV && div_last) begin
			reload_q[idx_q]    <= period;
			countdown_q[idx_q] <= period;
		end else if (state_q == ptb_pkg::S_APPLY && slot_ok_q
		             && action_q == ptb_pkg::ACT_RESTART) begin
			countdown_q[idx_q] <= rl_rd;
		end else if (state_q == ptb_pkg::S_TICK && alloc_q[idx_q] && enab_q[idx_q]) begin
			if (cd_rd != '0) begin
				countdown_q[idx_q] <= cd_rd - 1'b1;
			end else begin
				countdown_q[idx_q] <= rl_rd;
			end
		end
	end

	// Working registers: capture the transaction, run the divider and the slot walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q     <= ptb_pkg::ACT_NONE;
			res_status_q <= ptb_pkg::STAT_OK;
			res_grant_q  <= '0;
			res_fire_q   <= '0;
			idx_q        <= '0;
			slot_ok_q    <= 1'b0;
			div_cnt_q    <= '0;
		end else begin
			case (state_q)
				ptb_pkg::S_IDLE: begin
					if (in_fire) begin
						action_q     <= ptb_pkg::action_t'(action);
						slot_ok_q    <= in_slot_ok;
						res_status_q <= cap_status;
						res_grant_q  <= cap_grant;
						res_fire_q   <= '0;
						div_cnt_q    <= '0;
						idx_q        <= cap_idx;
					end
				end
				ptb_pkg::S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
				end
				ptb_pkg::S_TICK: begin
					if (alloc_q[idx_q] && enab_q[idx_q] && cd_rd == '0) begin
						res_fire_q[idx_q] <= 1'b1;
					end
					if (!last_slot) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Divider datapath and captured payload; no reset needed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			freq_q  <= frequency;
			start_q <= start_enabled;
			rem_q   <= '0;
			quo_q   <= tick_rate_q;
		end else if (state_q == ptb_pkg::S_DIV) begin
			rem_q <= trial_ge ? (trial - {1'b0, freq_q}) : trial;
			quo_q <= quo_next;
		end
	end

	// Output register; it frees when the receiver takes the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q  <= res_status_q;
			granted_q <= res_grant_q;
			fire_q    <= ptb_pkg::FIRE_W'(res_fire_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign fire_mask    = fire_q;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for periodic_timer_bank_core. A behavioral copy of
// the timer bank predicts the status, granted slot and fire mask of every
// accepted action. A monitor compares each output transaction with the oldest
// prediction. Directed tests cover the empty bank, a full table, zero
// frequencies and stale enabled marks. Random traffic then runs under several
// tick_rate settings, including both extremes and zero, with random stalls on
// both channels, and ends with a phase at full rate.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;

	// One expected output transaction.
	typedef struct {
		ptb_pkg::status_t                status;
		logic [ptb_pkg::SLOT_W-1:0]      granted;
		logic [ptb_pkg::FIRE_W-1:0]      fire;
	} timer_result_t;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            cfg_valid     = 1'b0;
	logic                            cfg_ready;
	logic [ptb_pkg::RATE_W-1:0]      cfg_data      = '0;
	logic                            in_valid      = 1'b0;
	logic                            in_ready;
	logic [ptb_pkg::ACTION_W-1:0]    action        = '0;
	logic [ptb_pkg::SLOT_W-1:0]      slot          = '0;
	logic [ptb_pkg::FREQ_W-1:0]      frequency     = '0;
	logic                            start_enabled = 1'b0;
	logic                            out_valid;
	logic                            out_ready     = 1'b0;
	logic [ptb_pkg::STATUS_W-1:0]    status;
	logic [ptb_pkg::SLOT_W-1:0]      granted_slot;
	logic [ptb_pkg::FIRE_W-1:0]      fire_mask;

	// Shadow copy of the bank and its register.
	logic [ptb_pkg::RATE_W-1:0]     bank_rate = ptb_pkg::TICK_RATE_RESET;
	logic                           bank_alloc [ptb_pkg::TIMER_SLOTS]   = '{default: 1'b0};
	logic                           bank_en [ptb_pkg::TIMER_SLOTS]      = '{default: 1'b0};
	logic                           reload_known [ptb_pkg::TIMER_SLOTS] = '{default: 1'b0};
	logic [ptb_pkg::COUNT_BITS-1:0] bank_count [ptb_pkg::TIMER_SLOTS]   = '{default: '0};
	logic [ptb_pkg::COUNT_BITS-1:0] bank_reload [ptb_pkg::TIMER_SLOTS]  = '{default: '0};

	timer_result_t expected_results [$];
	int            fail_count   = 0;
	int            stall_cycles = 0;
	bit            idle_on      = 1'b1;

	periodic_timer_bank_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.slot          (slot),
		.frequency     (frequency),
		.start_enabled (start_enabled),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_slot  (granted_slot),
		.fire_mask     (fire_mask)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Period of a slot: integer quotient, saturated to the counter width.
	function automatic logic [ptb_pkg::COUNT_BITS-1:0] period_for(
			logic [ptb_pkg::FREQ_W-1:0] fr);
		logic [31:0] q;
		q = 32'(bank_rate) / 32'(fr);
		if (q > 32'(ptb_pkg::COUNT_MASK))
			q = 32'(ptb_pkg::COUNT_MASK);
		return q[ptb_pkg::COUNT_BITS-1:0];
	endfunction

	// Applies one action to the shadow bank and returns its result.
	function automatic timer_result_t predict_action(ptb_pkg::action_t act,
			logic [ptb_pkg::SLOT_W-1:0] sl, logic [ptb_pkg::FREQ_W-1:0] fr, logic se);
		timer_result_t r;
		int            free_idx;
		bit            sl_ok;
		r.status  = ptb_pkg::STAT_OK;
		r.granted = '0;
		r.fire    = '0;
		sl_ok     = int'(sl) < ptb_pkg::TIMER_SLOTS;
		case (act)
			ptb_pkg::ACT_TICK: begin
				for (int i = 0; i < ptb_pkg::TIMER_SLOTS; i++) begin
					if (bank_alloc[i] && bank_en[i]) begin
						if (bank_count[i] != '0) begin
							bank_count[i] = bank_count[i] - 1'b1;
						end else begin
							if (i < ptb_pkg::FIRE_W)
								r.fire[i] = 1'b1;
							bank_count[i] = bank_reload[i];
						end
					end
				end
			end
			ptb_pkg::ACT_ADD: begin
				if (fr == '0) begin
					r.status = ptb_pkg::STAT_ZERO_FREQ;
				end else begin
					free_idx = -1;
					for (int i = 0; i < ptb_pkg::TIMER_SLOTS; i++)
						if (!bank_alloc[i] && free_idx < 0)
							free_idx = i;
					if (free_idx < 0) begin
						r.status = ptb_pkg::STAT_FULL;
					end else begin
						bank_alloc[free_idx]   = 1'b1;
						bank_en[free_idx]      = se;
						bank_reload[free_idx]  = period_for(fr);
						bank_count[free_idx]   = bank_reload[free_idx];
						reload_known[free_idx] = 1'b1;
						r.granted              = free_idx[ptb_pkg::SLOT_W-1:0];
					end
				end
			end
			ptb_pkg::ACT_DELETE: begin
				if (sl_ok)
					bank_alloc[sl] = 1'b0;
			end
			ptb_pkg::ACT_SET_FREQ: begin
				if (fr == '0) begin
					r.status = ptb_pkg::STAT_ZERO_FREQ;
				end else if (sl_ok) begin
					bank_reload[sl]  = period_for(fr);
					bank_count[sl]   = bank_reload[sl];
					reload_known[sl] = 1'b1;
				end
			end
			ptb_pkg::ACT_ENABLE: begin
				if (sl_ok)
					bank_en[sl] = 1'b1;
			end
			ptb_pkg::ACT_DISABLE: begin
				if (sl_ok)
					bank_en[sl] = 1'b0;
			end
			ptb_pkg::ACT_RESTART: begin
				if (sl_ok)
					bank_count[sl] = bank_reload[sl];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Sends one action, with an optional idle burst ahead of it.
	task automatic send_item(ptb_pkg::action_t act, logic [ptb_pkg::SLOT_W-1:0] sl,
			logic [ptb_pkg::FREQ_W-1:0] fr, logic se);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		slot          <= sl;
		frequency     <= fr;
		start_enabled <= se;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_action(act, sl, fr, se));
	endtask

	// Drops valid and waits until every predicted result has been seen.
	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// Writes tick_rate once the bank is idle.
	task automatic write_tick_rate(logic [ptb_pkg::RATE_W-1:0] value);
		wait_results_done();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		bank_rate = value;
		cfg_valid <= 1'b0;
	endtask

	// One random action, weighted toward ticks and short periods so that
	// slots actually fire. A restart only targets a slot with a known reload.
	task automatic send_random_item();
		int                         pick;
		int                         div;
		ptb_pkg::action_t           act;
		logic [ptb_pkg::SLOT_W-1:0] sl;
		logic [ptb_pkg::FREQ_W-1:0] fr;
		logic                       se;
		bit                         found;
		pick = $urandom_range(0, 99);
		if (pick < 40)      act = ptb_pkg::ACT_TICK;
		else if (pick < 55) act = ptb_pkg::ACT_ADD;
		else if (pick < 63) act = ptb_pkg::ACT_DELETE;
		else if (pick < 71) act = ptb_pkg::ACT_SET_FREQ;
		else if (pick < 79) act = ptb_pkg::ACT_ENABLE;
		else if (pick < 85) act = ptb_pkg::ACT_DISABLE;
		else if (pick < 95) act = ptb_pkg::ACT_RESTART;
		else                act = ptb_pkg::ACT_NONE;
		sl = ptb_pkg::SLOT_W'($urandom_range(0, 3));
		se = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			fr = '0;
		end else if (pick < 70) begin
			div = $urandom_range(1, 8);
			fr = ptb_pkg::FREQ_W'(32'(bank_rate) / div);
			if (fr == '0)
				fr = ptb_pkg::FREQ_W'($urandom_range(1, 65535));
		end else begin
			fr = ptb_pkg::FREQ_W'($urandom_range(0, 65535));
		end
		if (act == ptb_pkg::ACT_RESTART && !reload_known[sl]) begin
			found = 1'b0;
			for (int i = 0; i < ptb_pkg::TIMER_SLOTS; i++) begin
				if (reload_known[i] && !found) begin
					sl    = ptb_pkg::SLOT_W'(i);
					found = 1'b1;
				end
			end
			if (!found)
				act = ptb_pkg::ACT_TICK;
		end
		send_item(act, sl, fr, se);
	endtask

	// A run of random traffic with an occasional full drain in between.
	task automatic run_random_traffic(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) == 0)
				wait_results_done();
			send_random_item();
		end
	endtask

	// Responses of an empty bank at the reset tick_rate.
	task automatic test_idle_bank_responses();
		send_item(ptb_pkg::ACT_TICK, 2'd0, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_NONE, 2'd3, 16'hFFFF, 1'b1);
		send_item(ptb_pkg::ACT_ADD, 2'd0, 16'd0, 1'b1);
		send_item(ptb_pkg::ACT_SET_FREQ, 2'd2, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_ENABLE, 2'd3, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_DISABLE, 2'd3, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_DELETE, 2'd0, 16'd0, 1'b0);
	endtask

	// Fills the table, overflows it, and reuses a slot with a stale mark.
	task automatic test_slot_allocation();
		send_item(ptb_pkg::ACT_ADD, 2'd3, 16'hFFFF, 1'b1);
		send_item(ptb_pkg::ACT_ADD, 2'd0, 16'd1, 1'b0);
		send_item(ptb_pkg::ACT_ADD, 2'd1, 16'd50, 1'b1);
		send_item(ptb_pkg::ACT_ADD, 2'd2, 16'd100, 1'b1);
		send_item(ptb_pkg::ACT_ADD, 2'd0, 16'd7, 1'b1);
		send_item(ptb_pkg::ACT_TICK, 2'd0, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_TICK, 2'd0, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_TICK, 2'd0, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_RESTART, 2'd2, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_SET_FREQ, 2'd1, 16'd25, 1'b0);
		send_item(ptb_pkg::ACT_ENABLE, 2'd1, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_TICK, 2'd0, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_DELETE, 2'd1, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_ADD, 2'd0, 16'd33, 1'b0);
		send_item(ptb_pkg::ACT_TICK, 2'd0, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_DISABLE, 2'd0, 16'd0, 1'b0);
		send_item(ptb_pkg::ACT_TICK, 2'd0, 16'd0, 1'b0);
	endtask

	// Random traffic at the smallest, largest and zero tick_rate.
	task automatic test_tick_rate_extremes();
		write_tick_rate(16'd1);
		run_random_traffic(200);
		write_tick_rate(16'hFFFF);
		run_random_traffic(200);
		write_tick_rate(16'd0);
		run_random_traffic(200);
	endtask

	// Random traffic at random tick_rate values, mostly small ones.
	task automatic test_random_rates();
		for (int p = 0; p < 3; p++) begin
			if ($urandom_range(0, 1) == 0)
				write_tick_rate(ptb_pkg::RATE_W'($urandom_range(1, 40)));
			else
				write_tick_rate(ptb_pkg::RATE_W'($urandom_range(1, 65535)));
			run_random_traffic(250);
		end
	endtask

	// Closing phase with no idling on either side.
	task automatic test_back_to_back();
		write_tick_rate(ptb_pkg::RATE_W'($urandom_range(2, 30)));
		idle_on = 1'b0;
		run_random_traffic(400);
	endtask

	// Receiver: random stall bursts while idling is on.
	initial begin
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Compares every output transaction with the oldest prediction.
	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: status=%0d granted_slot=%0d fire_mask=%0h",
					status, granted_slot, fire_mask);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					fail_count++;
				end
				if (granted_slot !== want.granted) begin
					$error("granted_slot: expected %0d, actual %0d", want.granted, granted_slot);
					fail_count++;
				end
				if (fire_mask !== want.fire) begin
					$error("fire_mask: expected %0h, actual %0h", want.fire, fire_mask);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles in which no channel moves a transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles = stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Test sequence.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bank_responses();
		test_slot_allocation();
		test_tick_rate_extremes();
		test_random_rates();
		test_back_to_back();
		wait_results_done();
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
